// ----- rtl/nws_pkg.sv -----
// ----------------------------------------------------------------------------
// nws_pkg: shared types and constants for the nearest window selector
// Store geometry, payload formats, register indexes and the distance helper.
// ----------------------------------------------------------------------------
`default_nettype none

package nws_pkg;

  // store capacity and derived widths
  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // field widths
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 16;
  localparam int BOAT_W  = 16;
  localparam int KEEP_W  = 7;
  localparam int CMP_W   = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT   = 1'b1;
  localparam logic [KEEP_W-1:0]    KEEP_RESET       = 7'd64;

  // queue between intake and sorter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0] angle;
    logic [BOAT_W-1:0]  boat;
  } point_t;

  // one queued transaction: the point and whether it closes the set
  typedef struct packed {
    point_t pt;
    logic   last;
  } item_t;

  localparam int POINT_W = $bits(point_t);

  // absolute difference of two speeds
  function automatic logic [SPEED_W-1:0] speed_dist(input logic [SPEED_W-1:0] a,
                                                    input logic [SPEED_W-1:0] b);
    logic [SPEED_W-1:0] d;
    begin
      d = (a >= b) ? (a - b) : (b - a);
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nws_point_if.sv -----
// ----------------------------------------------------------------------------
// nws_point_if: input point channel
// Valid/ready channel carrying one measured point and the end-of-set mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface nws_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] wind_speed;
  logic [15:0] wind_angle;
  logic [15:0] boat_speed;
  logic        final_point;

  modport source (output valid, wind_speed, wind_angle, boat_speed, final_point,
                  input ready);
  modport sink   (input valid, wind_speed, wind_angle, boat_speed, final_point,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/nws_result_if.sv -----
// ----------------------------------------------------------------------------
// nws_result_if: kept point channel
// Valid/ready channel carrying one selected point with run end and loss flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface nws_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_speed;
  logic [15:0] out_angle;
  logic [15:0] out_boat_speed;
  logic        run_end;
  logic        overflowed;

  modport source (output valid, out_speed, out_angle, out_boat_speed, run_end,
                  overflowed, input ready);
  modport sink   (input valid, out_speed, out_angle, out_boat_speed, run_end,
                  overflowed, output ready);
endinterface

`default_nettype wire

// ----- rtl/nws_ram.sv -----
// ----------------------------------------------------------------------------
// nws_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/nws_front.sv -----
// ----------------------------------------------------------------------------
// nws_front: point intake
// Accepts point transactions, tags the end of a set and queues them for the
// sorter so intake and sorting stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module nws_front (
  input  wire logic           clk,
  input  wire logic           rst,
  nws_point_if.sink           points,
  output logic                q_valid,
  output nws_pkg::item_t      q_item,
  input  wire logic           q_pop
);

  nws_pkg::item_t slots [nws_pkg::QUEUE_DEPTH];
  nws_pkg::qptr_t wr_ptr;
  nws_pkg::qptr_t rd_ptr;
  nws_pkg::qcnt_t fill;
  nws_pkg::item_t in_item;
  logic           push;
  logic           pop;

  // classify the incoming transaction
  always_comb begin
    in_item.pt.speed = points.wind_speed;
    in_item.pt.angle = points.wind_angle;
    in_item.pt.boat  = points.boat_speed;
    in_item.last     = points.final_point;
  end

  assign points.ready = (fill != nws_pkg::qcnt_t'(nws_pkg::QUEUE_DEPTH));
  assign push         = points.valid & points.ready;
  assign q_valid      = (fill != '0);
  assign pop          = q_pop & q_valid;
  assign q_item       = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == nws_pkg::qptr_t'(nws_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == nws_pkg::qptr_t'(nws_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nws_back.sv -----
// ----------------------------------------------------------------------------
// nws_back: sorter, trimmer and emitter
// Inserts queued points into a sorted RAM store, trims the run from both ends
// around the target speed at the end of a set, then emits the survivors.
// ----------------------------------------------------------------------------
`default_nettype none

module nws_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire nws_pkg::item_t               q_item,
  output logic                              q_pop,
  input  wire logic [nws_pkg::SPEED_W-1:0]  target_speed,
  input  wire logic [nws_pkg::KEEP_W-1:0]   keep_count,
  nws_result_if.source                      results
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_CMP   = 4'd1;
  localparam logic [3:0] S_INS_PUT   = 4'd2;
  localparam logic [3:0] S_TRIM_INIT = 4'd3;
  localparam logic [3:0] S_TRIM_CHK  = 4'd4;
  localparam logic [3:0] S_LOAD_LO   = 4'd5;
  localparam logic [3:0] S_LOAD_HI   = 4'd6;
  localparam logic [3:0] S_EMIT_RD   = 4'd7;
  localparam logic [3:0] S_EMIT_LD   = 4'd8;

  logic [3:0]                   state, state_next;
  nws_pkg::cnt_t                count, count_next;
  logic                         lost, lost_next;
  nws_pkg::cnt_t                lo, lo_next;
  nws_pkg::cnt_t                hi, hi_next;
  nws_pkg::idx_t                pos, pos_next;
  nws_pkg::item_t               cur, cur_next;
  logic [nws_pkg::SPEED_W-1:0]  dist_lo, dist_lo_next;

  logic                         ram_we;
  nws_pkg::idx_t                ram_waddr;
  nws_pkg::point_t              ram_wdata;
  nws_pkg::idx_t                ram_raddr;
  logic [nws_pkg::POINT_W-1:0]  ram_rdata;
  nws_pkg::point_t              rd_pt;

  logic                         out_valid;
  logic                         out_load;
  nws_pkg::point_t              out_pt;
  logic                         out_end;
  logic                         out_lost;
  nws_pkg::cnt_t                width;
  nws_pkg::cnt_t                lo_inc;

  assign rd_pt  = nws_pkg::point_t'(ram_rdata);
  assign width  = hi - lo;
  assign lo_inc = lo + 1'b1;

  // sorted point store
  nws_ram #(
    .WIDTH (nws_pkg::POINT_W),
    .DEPTH (nws_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next   = state;
    count_next   = count;
    lost_next    = lost;
    lo_next      = lo;
    hi_next      = hi;
    pos_next     = pos;
    cur_next     = cur;
    dist_lo_next = dist_lo;
    ram_we       = 1'b0;
    ram_waddr    = pos;
    ram_wdata    = cur.pt;
    ram_raddr    = '0;
    q_pop        = 1'b0;
    out_load     = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_item;
          if (count == nws_pkg::cnt_t'(nws_pkg::MAX_POINTS)) begin
            // store full: drop the point, a final one still closes the set
            lost_next  = 1'b1;
            state_next = q_item.last ? S_TRIM_INIT : S_IDLE;
          end else if (count == '0) begin
            pos_next   = '0;
            state_next = S_INS_PUT;
          end else begin
            ram_raddr  = nws_pkg::idx_t'(count - 1'b1);
            pos_next   = nws_pkg::idx_t'(count);
            state_next = S_INS_CMP;
          end
        end
      end

      S_INS_CMP: begin
        if (rd_pt.speed > cur.pt.speed) begin
          // larger key moves up one slot
          ram_we    = 1'b1;
          ram_wdata = rd_pt;
          pos_next  = pos - 1'b1;
          if (pos == nws_pkg::idx_t'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            ram_raddr = pos - nws_pkg::idx_t'(2);
          end
        end else begin
          // equal keys keep arrival order
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          state_next = cur.last ? S_TRIM_INIT : S_IDLE;
        end
      end

      S_INS_PUT: begin
        ram_we     = 1'b1;
        count_next = count + 1'b1;
        state_next = cur.last ? S_TRIM_INIT : S_IDLE;
      end

      S_TRIM_INIT: begin
        lo_next    = '0;
        hi_next    = count;
        state_next = S_TRIM_CHK;
      end

      S_TRIM_CHK: begin
        if (nws_pkg::cmp_t'(width) > nws_pkg::cmp_t'(keep_count)) begin
          ram_raddr  = nws_pkg::idx_t'(lo);
          state_next = S_LOAD_LO;
        end else begin
          state_next = S_EMIT_RD;
        end
      end

      S_LOAD_LO: begin
        dist_lo_next = nws_pkg::speed_dist(target_speed, rd_pt.speed);
        ram_raddr    = nws_pkg::idx_t'(hi - 1'b1);
        state_next   = S_LOAD_HI;
      end

      S_LOAD_HI: begin
        // strictly closer low end drops the high end, ties drop the low end
        if (dist_lo < nws_pkg::speed_dist(target_speed, rd_pt.speed)) begin
          hi_next = hi - 1'b1;
        end else begin
          lo_next = lo_inc;
        end
        state_next = S_TRIM_CHK;
      end

      S_EMIT_RD: begin
        if (lo == hi) begin
          count_next = '0;
          lost_next  = 1'b0;
          state_next = S_IDLE;
        end else if (!out_valid || results.ready) begin
          ram_raddr  = nws_pkg::idx_t'(lo);
          state_next = S_EMIT_LD;
        end
      end

      S_EMIT_LD: begin
        out_load   = 1'b1;
        lo_next    = lo_inc;
        state_next = S_EMIT_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lost      <= 1'b0;
      lo        <= '0;
      hi        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      lost  <= lost_next;
      lo    <= lo_next;
      hi    <= hi_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    cur     <= cur_next;
    dist_lo <= dist_lo_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pt   <= rd_pt;
      out_end  <= (lo_inc == hi);
      out_lost <= lost;
    end
  end

  assign results.valid          = out_valid;
  assign results.out_speed      = out_pt.speed;
  assign results.out_angle      = out_pt.angle;
  assign results.out_boat_speed = out_pt.boat;
  assign results.run_end        = out_end;
  assign results.overflowed     = out_lost;

  // store fill never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= nws_pkg::cnt_t'(nws_pkg::MAX_POINTS))
    else $error("point count beyond capacity");

  // a result is loaded only into an empty output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD) |-> !out_valid)
    else $error("output register overwritten");

  // trim window stays inside the stored run
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM_CHK || state == S_EMIT_RD) |-> (lo <= hi && hi <= count))
    else $error("trim window outside stored run");

  // the store is cleared after each set is emitted
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD && lo == hi) |=> (count == '0 && !lost))
    else $error("set not cleared after emission");

endmodule

`default_nettype wire

// ----- rtl/nearest_window_select.sv -----
// ----------------------------------------------------------------------------
// nearest_window_select: keep the points nearest a target wind speed
// Collects a set of points sorted by wind speed and emits at most keep_count
// points around target_speed in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   points carries one point per transaction; final_point closes the set.
//   results carries the kept points in ascending wind speed order, run_end
//   on the last one, overflowed when the set lost points beyond 64.
//   cfg_we/cfg_index/cfg_data write target_speed (0) and keep_count (1);
//   write them only while the block is idle.
// Timing:
//   Points enter a two-entry queue, one transaction per cycle while it has
//   room. The sorter pops a point, then moves each stored point with a larger
//   speed up one RAM slot (one slot moved per cycle) before writing the new point.
//   After the final point, each dropped point passes TRIM_CHK, LOAD_LO and LOAD_HI
//   and each result EMIT_RD and EMIT_LD, sharing the single RAM read port.
// Reset:
//   Clears the set, the queue and the output; target_speed 0, keep_count 64.
//   The point store needs no clearing pass.
// Stall:
//   A stalled receiver holds the current result in the output register; the
//   emitter waits and the queue keeps taking points until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_window_select (
  input  wire logic                             clk,
  input  wire logic                             rst,
  nws_point_if.sink                             points,
  nws_result_if.source                          results,
  input  wire logic                             cfg_we,
  input  wire logic [nws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nws_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [nws_pkg::SPEED_W-1:0] target_speed;
  logic [nws_pkg::KEEP_W-1:0]  keep_count;
  logic                        q_valid;
  nws_pkg::item_t              q_item;
  logic                        q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed <= '0;
      keep_count   <= nws_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nws_pkg::REG_TARGET_SPEED: target_speed <= cfg_data[nws_pkg::SPEED_W-1:0];
        nws_pkg::REG_KEEP_COUNT:   keep_count   <= cfg_data[nws_pkg::KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // intake and queue
  nws_front u_front (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // sort, trim and emit
  nws_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .target_speed (target_speed),
    .keep_count   (keep_count),
    .results      (results)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for nearest_window_select
// Streams point sets through the block under random idling and stalls, holds
// an independent model of the sorted store and the window trim, and checks
// every kept point field by field against the predicted sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TICKS = 600;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 400;

  // one kept point as it leaves the block
  typedef struct packed {
    nws_pkg::point_t pt;
    logic            run_end;
    logic            overflowed;
  } kept_t;

  // model of the store, the trim and the pending kept points
  class window_scoreboard;
    nws_pkg::point_t             stored[$];
    bit                          lost;
    logic [nws_pkg::SPEED_W-1:0] target;
    logic [nws_pkg::KEEP_W-1:0]  keep;
    kept_t                       kept_expect[$];
    int                          mismatches;

    function new();
      lost       = 1'b0;
      target     = '0;
      keep       = nws_pkg::KEEP_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [nws_pkg::CFG_IDX_W-1:0] idx,
                            input logic [nws_pkg::CFG_DATA_W-1:0] data);
      if (idx == nws_pkg::REG_TARGET_SPEED) target = data[nws_pkg::SPEED_W-1:0];
      else if (idx == nws_pkg::REG_KEEP_COUNT) keep = data[nws_pkg::KEEP_W-1:0];
    endfunction

    function int gap(input logic [nws_pkg::SPEED_W-1:0] a,
                     input logic [nws_pkg::SPEED_W-1:0] b);
      return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // insert after equal keys; on the closing point trim and queue survivors
    function void note_point(input nws_pkg::point_t p, input bit last);
      int   pos;
      int   lo;
      int   hi;
      kept_t k;
      if (stored.size() >= nws_pkg::MAX_POINTS) begin
        lost = 1'b1;
      end else begin
        pos = stored.size();
        while (pos > 0 && stored[pos-1].speed > p.speed) pos--;
        stored.insert(pos, p);
      end
      if (last) begin
        lo = 0;
        hi = stored.size();
        while (hi - lo > int'(keep)) begin
          if (gap(target, stored[lo].speed) < gap(target, stored[hi-1].speed)) hi--;
          else lo++;
        end
        for (int i = lo; i < hi; i++) begin
          k.pt         = stored[i];
          k.run_end    = (i == hi - 1);
          k.overflowed = lost;
          kept_expect.push_back(k);
        end
        stored.delete();
        lost = 1'b0;
      end
    endfunction

    function void check_result(input kept_t got);
      kept_t want;
      if (kept_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected kept point: speed %h angle %h boat %h end %b ovf %b",
                   got.pt.speed, got.pt.angle, got.pt.boat, got.run_end,
                   got.overflowed);
      end else begin
        want = kept_expect.pop_front();
        if (got.pt.speed !== want.pt.speed || got.pt.angle !== want.pt.angle ||
            got.pt.boat !== want.pt.boat || got.run_end !== want.run_end ||
            got.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: want %h/%h/%h e%b o%b, got %h/%h/%h e%b o%b",
                     want.pt.speed, want.pt.angle, want.pt.boat, want.run_end,
                     want.overflowed, got.pt.speed, got.pt.angle, got.pt.boat,
                     got.run_end, got.overflowed);
        end
      end
    endfunction

    function bit failed();
      return (mismatches != 0) || (kept_expect.size() != 0);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [nws_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nws_pkg::CFG_DATA_W-1:0] cfg_data;

  nws_point_if  points_ch ();
  nws_result_if results_ch ();

  nearest_window_select dut (
    .clk       (clk),
    .rst       (rst),
    .points    (points_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  window_scoreboard sb;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_go;
  logic hold_on;
  int   cycle_count = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // long receiver hold-off, counted in its own process
  initial begin
    hold_on <= 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver: check each transaction, then pick the next ready
  always @(posedge clk) begin
    kept_t got;
    if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
      got.pt.speed   = results_ch.out_speed;
      got.pt.angle   = results_ch.out_angle;
      got.pt.boat    = results_ch.out_boat_speed;
      got.run_end    = results_ch.run_end;
      got.overflowed = results_ch.overflowed;
      sb.check_result(got);
    end
    if (hold_on === 1'b1) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one point, with random gaps, and wait for its transaction
  task automatic send_point(input logic [15:0] sp, input logic [15:0] an,
                            input logic [15:0] bs, input bit last);
    nws_pkg::point_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid       <= 1'b1;
    points_ch.wind_speed  <= sp;
    points_ch.wind_angle  <= an;
    points_ch.boat_speed  <= bs;
    points_ch.final_point <= last;
    do @(posedge clk); while (points_ch.ready !== 1'b1);
    p.speed = sp;
    p.angle = an;
    p.boat  = bs;
    sb.note_point(p, last);
  endtask

  // a set of random points clustered around a base speed
  task automatic send_set(input int count, input logic [15:0] base);
    logic [15:0] sp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       sp = 16'($urandom);
        1:       sp = base;
        default: sp = base + 16'($urandom_range(0, 255));
      endcase
      send_point(sp, 16'($urandom), 16'($urandom), i == count - 1);
    end
  endtask

  // drain all kept points and let the trim logic settle
  task automatic wait_idle();
    points_ch.valid <= 1'b0;
    while (sb.kept_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic configure(input logic [15:0] target_data, input logic [15:0] keep_data);
    cfg_we    <= 1'b1;
    cfg_index <= nws_pkg::REG_TARGET_SPEED;
    cfg_data  <= target_data;
    @(posedge clk);
    sb.write_reg(nws_pkg::REG_TARGET_SPEED, target_data);
    cfg_index <= nws_pkg::REG_KEEP_COUNT;
    cfg_data  <= keep_data;
    @(posedge clk);
    sb.write_reg(nws_pkg::REG_KEEP_COUNT, keep_data);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] target_data;
    logic [15:0] keep_data;
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b0;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    points_ch.valid        <= 1'b0;
    points_ch.wind_speed   <= '0;
    points_ch.wind_angle   <= '0;
    points_ch.boat_speed   <= '0;
    points_ch.final_point  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: single extreme point
    send_point(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    // equal keys keep arrival order
    send_point(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_point(16'h8000, 16'h1234, 16'h5678, 1'b0);
    send_point(16'h0000, 16'h0001, 16'h0002, 1'b0);
    send_point(16'h7FFF, 16'hAAAA, 16'h5555, 1'b0);
    send_point(16'h0000, 16'h5555, 16'hAAAA, 1'b1);
    wait_idle();

    // distance tie drops the low end, closer low end survives
    configure(16'h1000, 16'd1);
    send_point(16'h0F00, 16'h0101, 16'h0202, 1'b0);
    send_point(16'h1100, 16'h0303, 16'h0404, 1'b1);
    send_point(16'h0FFF, 16'h0505, 16'h0606, 1'b0);
    send_point(16'h1100, 16'h0707, 16'h0808, 1'b1);
    wait_idle();

    // keep count data with upper bits set, top target
    configure(16'hFFFF, 16'hFF83);
    for (int i = 0; i < 5; i++)
      send_point(16'hF000 - 16'(i * 16'h0100), 16'($urandom), 16'($urandom), i == 4);
    wait_idle();

    // keep count zero emits nothing
    configure(16'h8000, 16'd0);
    send_point(16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h8001, 16'h0000, 16'h0000, 1'b1);
    wait_idle();

    // random groups of sets under rotating idle modes
    for (int g = 0; g < 10; g++) begin
      case (g % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 59; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      case (g)
        0:       begin target_data = 16'h0000; keep_data = 16'd64;   end
        1:       begin target_data = 16'hFFFF; keep_data = 16'd1;    end
        2:       begin target_data = 16'($urandom); keep_data = 16'hFFC0; end
        3:       begin
          target_data = 16'($urandom);
          keep_data   = 16'($urandom_range(1, 8));
        end
        4:       begin target_data = 16'($urandom); keep_data = 16'h0080; end
        5:       begin
          target_data = 16'($urandom);
          keep_data   = 16'($urandom_range(5, 20));
        end
        default: begin
          target_data = 16'($urandom);
          keep_data   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 64));
        end
      endcase
      configure(target_data, keep_data);
      // long receiver hold-off while two sets back up into the input
      if (g == 3) begin
        hold_go = 1'b1;
        send_set(4, target_data);
        send_set(4, target_data);
      end
      // store fills exactly and the closing point is lost
      if (g == 2) send_set(nws_pkg::MAX_POINTS + 1, 16'($urandom));
      // store overflows by three points
      if (g == 5) send_set(nws_pkg::MAX_POINTS + 3, target_data);
      for (int s = 0; s < 2; s++)
        send_set($urandom_range(1, 9),
                 ($urandom_range(0, 1) == 0) ? target_data : 16'($urandom));
      wait_idle();
    end

    if (!sb.failed()) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/nws_pkg.sv
rtl/nws_point_if.sv
rtl/nws_result_if.sv
rtl/nws_ram.sv
rtl/nws_front.sv
rtl/nws_back.sv
rtl/nearest_window_select.sv
tb/tb.sv
